@@ src/irt_pkg.sv @@
package irt_pkg;

    localparam int VALUE_W  = 64;
    localparam int RADIX_W  = 6;
    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 6;
    localparam int DEPTH    = 64;
    localparam int PTR_W    = 6;
    localparam int CNT_W    = 7;
    localparam int PC_W     = 3;
    localparam int DIV_BITS = 4;
    localparam int ITER_W   = 4;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_DEC = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2d;

    // datapath operation of one microstep
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_STEP,
        OP_STORE,
        OP_MINUS,
        OP_READ,
        OP_EMIT
    } t_op;

    // condition the step waits on before it executes
    typedef enum logic [1:0] {
        W_ALWAYS,
        W_IN_VALID,
        W_OUT_FREE
    } t_wait;

    // branch condition, otherwise fall through to pc + 1
    typedef enum logic [2:0] {
        J_NEVER,
        J_ALWAYS,
        J_DIV_MORE,
        J_MORE_DIGITS,
        J_PTR_ZERO
    } t_jump;

    typedef struct packed {
        t_op             op;
        t_wait           wait_on;
        t_jump           jump;
        logic [PC_W-1:0] target;
    } t_ucode;

    typedef struct packed {
        logic load;
        logic clear;
        logic step;
    } t_div_ctrl;

    localparam logic [PC_W-1:0] PC_LOAD  = 3'd0;
    localparam logic [PC_W-1:0] PC_DIV   = 3'd1;
    localparam logic [PC_W-1:0] PC_STORE = 3'd2;
    localparam logic [PC_W-1:0] PC_MINUS = 3'd3;
    localparam logic [PC_W-1:0] PC_READ  = 3'd4;
    localparam logic [PC_W-1:0] PC_EMIT  = 3'd5;
    localparam logic [PC_W-1:0] PC_LOOP  = 3'd6;
    localparam logic [PC_W-1:0] PC_SPARE = 3'd7;

    function automatic t_ucode ucode_rom(input logic [PC_W-1:0] pc);
        t_ucode w;
        unique case (pc)
            PC_LOAD:  w = '{OP_LOAD,     W_IN_VALID, J_NEVER,       PC_LOAD};
            PC_DIV:   w = '{OP_DIV_STEP, W_ALWAYS,   J_DIV_MORE,    PC_DIV};
            PC_STORE: w = '{OP_STORE,    W_ALWAYS,   J_MORE_DIGITS, PC_DIV};
            PC_MINUS: w = '{OP_MINUS,    W_OUT_FREE, J_NEVER,       PC_LOAD};
            PC_READ:  w = '{OP_READ,     W_ALWAYS,   J_NEVER,       PC_LOAD};
            PC_EMIT:  w = '{OP_EMIT,     W_OUT_FREE, J_PTR_ZERO,    PC_LOAD};
            PC_LOOP:  w = '{OP_NONE,     W_ALWAYS,   J_ALWAYS,      PC_READ};
            default:  w = '{OP_NONE,     W_ALWAYS,   J_ALWAYS,      PC_LOAD};
        endcase
        return w;
    endfunction

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] c;
        if (r < RADIX_MIN) begin
            c = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            c = RADIX_MAX;
        end else begin
            c = r;
        end
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_DEC) begin
            c = CHAR_ZERO + {2'b00, d};
        end else begin
            c = CHAR_LOWER_A + {2'b00, d - DIGIT_DEC};
        end
        return c;
    endfunction

endpackage

@@ src/irt_if.sv @@
interface irt_in_if import irt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic        [RADIX_W-1:0] radix;

    modport source (output valid, value, radix, input ready);
    modport sink   (input valid, value, radix, output ready);
endinterface

interface irt_out_if import irt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last;

    modport source (output valid, char_code, last, input ready);
    modport sink   (input valid, char_code, last, output ready);
endinterface

@@ src/irt_div.sv @@
// radix divider: restoring division, DIV_BITS quotient bits per cycle in which step is set
module irt_div import irt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_div_ctrl           i_ctrl,
    input  logic [VALUE_W-1:0]  i_dividend,
    input  logic [RADIX_W-1:0]  i_radix,
    output logic [VALUE_W-1:0]  o_quo,
    output logic [DIGIT_W-1:0]  o_rem,
    output logic                o_last_step
);

    logic [VALUE_W-1:0] r_quo, n_quo;
    logic [DIGIT_W-1:0] r_rem, n_rem;
    logic [RADIX_W-1:0] r_base;
    logic [ITER_W-1:0]  r_iter;

    always_comb begin
        logic [DIGIT_W:0] t;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int i = 0; i < DIV_BITS; i++) begin
            t     = {n_rem, n_quo[VALUE_W-1]};
            n_quo = {n_quo[VALUE_W-2:0], 1'b0};
            if (t >= {1'b0, r_base}) begin
                t        = t - {1'b0, r_base};
                n_quo[0] = 1'b1;
            end
            n_rem = t[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= '0;
        end else if (i_ctrl.load || i_ctrl.clear) begin
            r_iter <= '0;
        end else if (i_ctrl.step) begin
            r_iter <= r_iter + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_base <= clamp_radix(i_radix);
        end else if (i_ctrl.clear) begin
            r_rem  <= '0;
        end else if (i_ctrl.step) begin
            r_quo  <= n_quo;
            r_rem  <= n_rem;
        end
    end

    assign o_quo       = r_quo;
    assign o_rem       = r_rem;
    assign o_last_step = (r_iter == ITER_W'(VALUE_W / DIV_BITS - 1));

endmodule

@@ src/integer_to_radix_ascii.sv @@
// Integer to radix ASCII converter. One request on i_in carries a signed 64-bit
// value and a radix (0 and 1 act as 2, 37..63 act as 36); the block answers with
// the digits most significant first, one character per request on o_out, 'last'
// set on the final one. Digits above 9 are lowercase letters. A '-' leads only
// for a negative value in radix 10; in every other radix a negative value prints
// as its unsigned 64-bit pattern. One number is converted at a time: i_in.ready
// is high only while the sequencer waits for a new number. Each digit takes a
// pass of the divider, restoring steps of 4 quotient bits across the 64-bit
// value, then a store into the digit memory; each character is then read back
// from that memory and emitted. Radix 10 needs at most 19 digits, radix 2 up
// to 64 for a full 64-bit pattern.
module integer_to_radix_ascii import irt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    irt_in_if.sink    i_in,
    irt_out_if.source o_out
);

    // microsequencer
    logic [PC_W-1:0] r_pc, n_pc;
    t_ucode          uw;
    logic            go;
    logic            take;

    // datapath
    t_div_ctrl          div_ctrl;
    logic [VALUE_W-1:0] div_quo;
    logic [DIGIT_W-1:0] div_rem;
    logic               div_last;

    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   r_ptr;
    logic               r_minus;
    logic [DIGIT_W-1:0] r_rd;
    logic [DIGIT_W-1:0] r_mem [DEPTH];

    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic               out_free;

    logic               in_minus;
    logic [VALUE_W-1:0] in_mag;

    assign uw       = ucode_rom(r_pc);
    assign out_free = !r_out_valid || o_out.ready;

    // a negative value only gets sign-magnitude treatment in decimal
    assign in_minus = (clamp_radix(i_in.radix) == RADIX_DEC) && i_in.value[VALUE_W-1];
    assign in_mag   = in_minus ? VALUE_W'(-i_in.value) : VALUE_W'(i_in.value);

    always_comb begin
        unique case (uw.wait_on)
            W_IN_VALID: go = i_in.valid;
            W_OUT_FREE: go = out_free;
            default:    go = 1'b1;
        endcase

        unique case (uw.jump)
            J_ALWAYS:      take = 1'b1;
            J_DIV_MORE:    take = !div_last;
            // keep dividing until the quotient is gone or the store is full
            J_MORE_DIGITS: take = (div_quo != '0) && (r_count != CNT_W'(DEPTH - 1));
            J_PTR_ZERO:    take = (r_ptr == '0);
            default:       take = 1'b0;
        endcase

        if (!go) begin
            n_pc = r_pc;
        end else if (take) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end

        div_ctrl.load  = go && (uw.op == OP_LOAD);
        div_ctrl.step  = go && (uw.op == OP_DIV_STEP);
        div_ctrl.clear = go && (uw.op == OP_STORE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

    irt_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (div_ctrl),
        .i_dividend  (in_mag),
        .i_radix     (i_in.radix),
        .o_quo       (div_quo),
        .o_rem       (div_rem),
        .o_last_step (div_last)
    );

    assign i_in.ready = (uw.op == OP_LOAD);

    // digit count, readback pointer and sign flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
            r_minus <= 1'b0;
        end else if (go) begin
            case (uw.op)
                OP_LOAD: begin
                    r_count <= '0;
                    r_minus <= in_minus;
                end
                OP_STORE: r_count <= r_count + 1'b1;
                OP_MINUS: r_ptr   <= PTR_W'(r_count - 1'b1);
                OP_EMIT:  r_ptr   <= r_ptr - 1'b1;
                default: ;
            endcase
        end
    end

    // digit memory, least significant digit first
    always_ff @(posedge i_clk) begin
        if (go && (uw.op == OP_STORE)) begin
            r_mem[r_count[PTR_W-1:0]] <= div_rem;
        end
        if (go && (uw.op == OP_READ)) begin
            r_rd <= r_mem[r_ptr];
        end
    end

    // output register: holds a character while the sequencer moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && (uw.op == OP_EMIT)) begin
            r_out_valid <= 1'b1;
        end else if (go && (uw.op == OP_MINUS) && r_minus) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && (uw.op == OP_EMIT)) begin
            r_char <= digit_char(r_rd);
            r_last <= (r_ptr == '0);
        end else if (go && (uw.op == OP_MINUS)) begin
            r_char <= CHAR_MINUS;
            r_last <= 1'b0;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_char;
    assign o_out.last      = r_last;

endmodule

@@ src/irt_checker.sv @@
module irt_checker import irt_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CHAR_W-1:0] i_out_char,
    input logic              i_out_last
);

    // stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char) && $stable(i_out_last))
        else $error("output request changed while stalled");

    // one number at a time: busy right after a new request
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again while converting");

    // ready for a new number only once the pending character is the final one
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready && i_out_valid |-> i_out_last)
        else $error("ready for a new number before the last character");

    // character set and sign placement
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_out_char == CHAR_MINUS && !i_out_last) ||
            (i_out_char >= CHAR_ZERO && i_out_char <= 8'h39) ||
            (i_out_char >= CHAR_LOWER_A && i_out_char <= 8'h7a))
        else $error("illegal character or trailing minus");

endmodule

bind integer_to_radix_ascii irt_checker u_irt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.char_code),
    .i_out_last  (o_out.last)
);

@@ tb/sv/ascii_digit_checker.sv @@
`timescale 1ns / 1ps

module ascii_digit_checker import irt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    irt_in_if    i_num,
    irt_out_if   i_chr,
    output int   o_mismatches,
    output int   o_chars_pending,
    output int   o_chars_checked
);

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_spelled_char;

    t_spelled_char pending_chars[$];
    int mismatches    = 0;
    int chars_checked = 0;
    int pending_count = 0;

    assign o_mismatches    = mismatches;
    assign o_chars_pending = pending_count;
    assign o_chars_checked = chars_checked;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("[%0t] MISMATCH after %0d chars: %s", $time, chars_checked, what);
        end
    endtask

    // Queue the characters one number spells: optional '-', digits MS first.
    function automatic void spell_number(input logic [VALUE_W-1:0] value,
                                         input logic [RADIX_W-1:0] radix_code);
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] mag;
        logic [DIGIT_W-1:0] digit_vals[DEPTH];
        logic [DIGIT_W-1:0] d;
        logic               with_minus;
        t_spelled_char      ch;
        int                 ndig;
        int                 k;

        if (radix_code < RADIX_MIN) begin
            base = VALUE_W'(RADIX_MIN);
        end else if (radix_code > RADIX_MAX) begin
            base = VALUE_W'(RADIX_MAX);
        end else begin
            base = VALUE_W'(radix_code);
        end

        // only decimal gets a sign; 2^63 wraps to itself, which is the magnitude
        with_minus = (base == VALUE_W'(RADIX_DEC)) && value[VALUE_W-1];
        mag        = with_minus ? ({VALUE_W{1'b0}} - value) : value;

        ndig = 0;
        do begin
            digit_vals[ndig] = DIGIT_W'(mag % base);
            mag              = mag / base;
            ndig++;
        end while (mag != 0 && ndig < DEPTH);

        if (with_minus) begin
            ch.code = CHAR_MINUS;
            ch.last = 1'b0;
            pending_chars.push_back(ch);
        end
        for (k = ndig - 1; k >= 0; k--) begin
            d       = digit_vals[k];
            ch.code = (d < DIGIT_DEC) ? CHAR_ZERO + CHAR_W'(d)
                                      : CHAR_LOWER_A + CHAR_W'(d) - CHAR_W'(DIGIT_DEC);
            ch.last = (k == 0);
            pending_chars.push_back(ch);
        end
    endfunction

    // characters are checked before a new number is queued, so an early
    // character can never match the front of a number taken on the same edge
    always @(posedge i_clk) begin
        t_spelled_char want;
        if (i_rst_n) begin
            if (i_chr.valid && i_chr.ready) begin
                if (pending_chars.size() == 0) begin
                    report_mismatch($sformatf("char %02h last %0b with nothing owed",
                                              i_chr.char_code, i_chr.last));
                end else begin
                    want = pending_chars.pop_front();
                    chars_checked++;
                    if (i_chr.char_code !== want.code) begin
                        report_mismatch($sformatf("char_code %02h, wanted %02h",
                                                  i_chr.char_code, want.code));
                    end
                    if (i_chr.last !== want.last) begin
                        report_mismatch($sformatf("last %0b, wanted %0b on char %02h",
                                                  i_chr.last, want.last, want.code));
                    end
                end
            end
            if (i_num.valid && i_num.ready) begin
                spell_number(i_num.value, i_num.radix);
            end
        end
        pending_count = pending_chars.size();
    end

endmodule

@@ tb/sv/integer_to_radix_ascii_test.sv @@
`timescale 1ns / 1ps

module integer_to_radix_ascii_test;
    import irt_pkg::*;

    localparam int          RESET_CYCLES     = 9;
    localparam int          RANDOM_PER_PHASE = 150;
    // output hold-off: starts once this many numbers went in, lasts HOLD_LEN
    localparam int          HOLD_START       = 60;
    localparam int          HOLD_LEN         = 2500;
    // quiet time once nothing is owed, to catch stray characters
    localparam int          DRAIN_CYCLES     = 100;
    // the limit leaves room for the slowest legal run (64 chars per number, long stalls)
    localparam int unsigned CYCLE_LIMIT      = 4_000_000;

    localparam logic signed [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};

    logic i_clk;
    logic i_rst_n;

    irt_in_if  num_bus ();
    irt_out_if char_bus ();

    int unsigned cycle_count = 0;
    int unsigned send_gap_pct;      // chance per cycle that the sender idles
    int unsigned recv_stall_pct;    // chance per cycle that the receiver stalls
    int          numbers_sent = 0;
    int          hold_cycles;
    bit          out_hold;

    int mismatch_count;
    int chars_pending;
    int chars_checked;

    integer_to_radix_ascii DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (num_bus),
        .o_out   (char_bus)
    );

    ascii_digit_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_num           (num_bus),
        .i_chr           (char_bus),
        .o_mismatches    (mismatch_count),
        .o_chars_pending (chars_pending),
        .o_chars_checked (chars_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // One request: random idle cycles first, then hold valid until taken.
    // Every drive happens at a falling edge; the handshake is read at the
    // rising edge, before the block updates ready.
    task automatic send_number(input logic signed [VALUE_W-1:0] value,
                               input logic [RADIX_W-1:0] radix);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            num_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        num_bus.valid <= 1'b1;
        num_bus.value <= value;
        num_bus.radix <= radix;
        do @(posedge i_clk); while (!num_bus.ready);
        numbers_sent++;
    endtask

    initial begin : stimulus
        logic signed [VALUE_W-1:0] v;
        logic [RADIX_W-1:0]        r;
        int                        phase;
        int                        n;

        i_rst_n       <= 1'b0;
        num_bus.valid <= 1'b0;
        num_bus.value <= '0;
        num_bus.radix <= '0;
        send_gap_pct   = 28;
        recv_stall_pct = 51;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: zero, extremes, sign rule, radix clamping ---
        send_number(64'sd0, RADIX_DEC);
        send_number(64'sd0, 6'd2);
        send_number(64'sd0, 6'd0);
        send_number(64'sd0, 6'd63);
        send_number(MOST_NEG, RADIX_DEC);     // magnitude 2^63 with a '-'
        send_number(MOST_NEG, 6'd2);          // 64 binary digits
        send_number(MOST_NEG, 6'd16);
        send_number(-64'sd1, RADIX_DEC);
        send_number(-64'sd1, 6'd2);           // 64 ones, no sign
        send_number(-64'sd1, 6'd36);
        send_number(MOST_POS, RADIX_DEC);
        send_number(MOST_POS, 6'd36);
        send_number(64'sd35, 6'd36);          // single 'z'
        send_number(64'sd36, 6'd36);
        send_number(64'sd12345, 6'd0);        // below range acts as binary
        send_number(64'sd12345, 6'd1);
        send_number(64'sd255, 6'd37);         // above range acts as base 36
        send_number(64'sd255, 6'd63);
        send_number(-64'sd255, 6'd63);
        send_number(64'sd9, RADIX_DEC);
        send_number(64'sd10, RADIX_DEC);
        send_number(-64'sd10, 6'd16);
        send_number(-64'sd1234567890, RADIX_DEC);
        send_number(64'sd3735928559, 6'd16);
        send_number(-64'sd8, 6'd8);

        // --- random: three idle mixes, the last one with no idling ---
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct   = 28;
                    recv_stall_pct = 51;
                end
                1: begin
                    send_gap_pct   = 51;
                    recv_stall_pct = 28;
                end
                default: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                case ($urandom_range(9))
                    0, 1, 2: v = {$urandom, $urandom};
                    3, 4:    v = VALUE_W'($urandom_range(999));
                    5:       v = 64'd0 - VALUE_W'($urandom_range(999));
                    // powers of two and one below them
                    6:       v = (64'd1 << $urandom_range(63)) - VALUE_W'($urandom_range(1));
                    7:       v = MOST_NEG + VALUE_W'($urandom_range(3));
                    8:       v = MOST_POS - VALUE_W'($urandom_range(3));
                    default: v = 64'd0 - VALUE_W'($urandom);
                endcase
                // any 6-bit code now and then, decimal often, else a legal radix
                case ($urandom_range(7))
                    0:       r = RADIX_W'($urandom_range(63));
                    1, 2:    r = RADIX_DEC;
                    default: r = RADIX_W'($urandom_range(36, 2));
                endcase
                send_number(v, r);
            end
        end

        @(negedge i_clk);
        num_bus.valid <= 1'b0;

        wait (chars_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d numbers: zero, both 64-bit extremes, clamped radix codes,",
                 numbers_sent);
        $display("three idle mixes and a %0d-cycle output hold-off; %0d characters checked",
                 HOLD_LEN, chars_checked);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Receiver: random stalls at the current rate, fully blocked during the
    // hold-off so the block fills up and has to refuse new numbers.
    initial begin : char_sink
        char_bus.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            char_bus.ready <= !out_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : output_hold_off
        out_hold = 1'b0;
        wait (numbers_sent >= HOLD_START);
        @(posedge i_clk);
        out_hold = 1'b1;
        for (hold_cycles = 0; hold_cycles < HOLD_LEN; hold_cycles++) begin
            @(posedge i_clk);
        end
        out_hold = 1'b0;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout at cycle %0d, %0d characters still owed", cycle_count,
                 chars_pending);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
